@@ rtl/core/oitt_pkg.sv @@
// ----------------------------------------------------------------------------
// oitt_pkg
// Shared codes, defaults and controller/datapath link types for the
// open inode tracking table.
// ----------------------------------------------------------------------------
package oitt_pkg;

    // default table depth
    localparam int OITT_ENTRIES = 64;

    // field widths
    localparam int MODE_W   = 2;
    localparam int INODE_W  = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TAG   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic clr;    // write zero at the sweep address and advance
        logic start;  // latch the request word and rewind the scan
        logic scan;   // issue reads and compare
        logic wr;     // write the matching slot
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;   // sweep address is at the last slot
        logic hit;        // slot under compare matches the key
        logic scan_last;  // slot under compare is the last slot
    } t_stat;

endpackage

@@ rtl/core/oitt_dp.sv @@
// ----------------------------------------------------------------------------
// oitt_dp
// Slot memory with a sweep/scan address counter, registered read port and
// key compare. Writes the matching slot on command.
// ----------------------------------------------------------------------------
module oitt_dp #(
    parameter int ENTRIES = oitt_pkg::OITT_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  oitt_pkg::t_cmd                i_cmd,
    input  logic [oitt_pkg::MODE_W-1:0]   i_mode,
    input  logic [oitt_pkg::INODE_W-1:0]  i_inode,
    output oitt_pkg::t_stat               o_stat
);
    import oitt_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    logic [INODE_W-1:0] mem [ENTRIES];

    logic [AW-1:0]      r_addr;
    logic               r_issue;
    logic [AW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic [INODE_W-1:0] r_rd_data;
    logic [INODE_W-1:0] r_key;
    logic [INODE_W-1:0] r_wdata;

    logic [AW-1:0]      n_wr_addr;
    logic [INODE_W-1:0] n_wr_data;
    logic               n_wr_en;

    // address counter and read pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.clr) begin
            if (r_addr != LAST) begin
                r_addr <= r_addr + AW'(1);
            end
        end else if (i_cmd.start) begin
            r_addr   <= '0;
            r_issue  <= 1'b1;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= r_issue;
            r_rd_idx <= r_addr;
            if (r_issue) begin
                if (r_addr == LAST) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + AW'(1);
                end
            end
        end
    end

    // request word: a tag searches for a free slot and writes the number
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key   <= (i_mode == MODE_TAG) ? '0 : i_inode;
            r_wdata <= (i_mode == MODE_TAG) ? i_inode : '0;
        end
    end

    // write port select
    always_comb begin
        n_wr_en   = i_cmd.clr | i_cmd.wr;
        n_wr_addr = i_cmd.clr ? r_addr : r_rd_idx;
        n_wr_data = i_cmd.clr ? '0 : r_wdata;
    end

    // slot memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            mem[n_wr_addr] <= n_wr_data;
        end
        if (i_cmd.scan && r_issue) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // compare and end of scan
    always_comb begin
        o_stat.clr_last  = (r_addr == LAST);
        o_stat.hit       = r_rd_vld && (r_rd_data == r_key);
        o_stat.scan_last = r_rd_vld && (r_rd_idx == LAST);
    end

endmodule

@@ rtl/core/oitt_ctrl.sv @@
// ----------------------------------------------------------------------------
// oitt_ctrl
// Sequencer for the table: clearing sweep after reset, one request at a
// time, scan until first match or end, then hold the status word.
// ----------------------------------------------------------------------------
module oitt_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [oitt_pkg::MODE_W-1:0]    i_mode,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [oitt_pkg::STATUS_W-1:0]  o_status,
    output oitt_pkg::t_cmd                 o_cmd,
    input  oitt_pkg::t_stat                i_stat
);
    import oitt_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    t_state               r_state;
    logic [MODE_W-1:0]    r_mode;
    logic                 r_valid;
    logic [STATUS_W-1:0]  r_status;
    logic                 n_accept;
    logic [STATUS_W-1:0]  n_hit_status;
    logic [STATUS_W-1:0]  n_miss_status;

    assign n_accept = (r_state == S_IDLE) && i_valid;

    // status for a found and a missed slot
    always_comb begin
        case (r_mode)
            MODE_CHECK: begin
                n_hit_status  = ST_PRESENT;
                n_miss_status = ST_OK;
            end
            MODE_TAG: begin
                n_hit_status  = ST_OK;
                n_miss_status = ST_FULL;
            end
            MODE_FREE: begin
                n_hit_status  = ST_OK;
                n_miss_status = ST_MISSING;
            end
            default: begin
                n_hit_status  = ST_OK;
                n_miss_status = ST_OK;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd.clr   = (r_state == S_CLEAR);
        o_cmd.start = n_accept && (i_mode != MODE_NOP);
        o_cmd.scan  = (r_state == S_SCAN);
        o_cmd.wr    = (r_state == S_SCAN) && i_stat.hit
                      && ((r_mode == MODE_TAG) || (r_mode == MODE_FREE));
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_stat.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (n_accept) begin
                        r_mode <= i_mode;
                        if (i_mode == MODE_NOP) begin
                            r_status <= ST_OK;
                            r_valid  <= 1'b1;
                            r_state  <= S_RESP;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (i_stat.hit) begin
                        r_status <= n_hit_status;
                        r_valid  <= 1'b1;
                        r_state  <= S_RESP;
                    end else if (i_stat.scan_last) begin
                        r_status <= n_miss_status;
                        r_valid  <= 1'b1;
                        r_state  <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule

@@ rtl/core/open_inode_tracking_table.sv @@
// ----------------------------------------------------------------------------
// Each accepted word rewinds the scan, which reads the slots in order from
//   index 0 over the registered read port and registers the status on the
//   first match or after the last slot; the unused mode skips the scan.
// Throughput: one word at a time, set by the slot-by-slot scan over the single
//   read port of the slot memory.
// Reset: a clearing sweep zeroes every slot; input is stalled until it ends.
// ----------------------------------------------------------------------------
// open_inode_tracking_table
// Set table of open inode numbers: check, tag into the lowest free slot and
// free the lowest matching slot, answered with one status word each.
// ----------------------------------------------------------------------------
module open_inode_tracking_table #(
    parameter int ENTRIES = oitt_pkg::OITT_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [oitt_pkg::MODE_W-1:0]    i_mode,
    input  logic [oitt_pkg::INODE_W-1:0]   i_inode,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [oitt_pkg::STATUS_W-1:0]  o_status
);
    import oitt_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    oitt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_mode   (i_mode),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_cmd    (w_cmd),
        .i_stat   (w_stat)
    );

    // slot memory and compare
    oitt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_mode  (i_mode),
        .i_inode (i_inode),
        .o_stat  (w_stat)
    );

    // busy after every accepted word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while previous word in flight");

    // no input taken while a status word is pending
    a_stall_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while status word pending");

    // a slot write only happens during a scan with a match
    a_write_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr |-> (w_cmd.scan && w_stat.hit))
        else $error("slot write without a match");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("status word after reset");

endmodule
